### hw/rtl/aame_pkg.sv
// Shared types and constants for the ALU / multiply execute block.
// No dependencies; imported by every module of the block.
package aame_pkg;

    localparam int NUM_REGS = 16;
    localparam int IDX_W    = $clog2(NUM_REGS);
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 5;

    // Operation codes: data-processing opcodes first, then the multiply forms
    typedef enum logic [FUNC_W-1:0] {
        FN_AND  = 5'd0,
        FN_EOR  = 5'd1,
        FN_SUB  = 5'd2,
        FN_RSB  = 5'd3,
        FN_ADD  = 5'd4,
        FN_ADC  = 5'd5,
        FN_SBC  = 5'd6,
        FN_RSC  = 5'd7,
        FN_TST  = 5'd8,
        FN_TEQ  = 5'd9,
        FN_CMP  = 5'd10,
        FN_CMN  = 5'd11,
        FN_ORR  = 5'd12,
        FN_MOV  = 5'd13,
        FN_BIC  = 5'd14,
        FN_MVN  = 5'd15,
        FN_MUL  = 5'd16,
        FN_MLA  = 5'd17,
        FN_MULL = 5'd18,
        FN_MLAL = 5'd19
    } t_func;

    // Condition flags
    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    // Register file write request, up to two registers per beat
    typedef struct packed {
        logic              lo_en;
        logic [IDX_W-1:0]  lo_idx;
        logic [DATA_W-1:0] lo_data;
        logic              hi_en;
        logic [IDX_W-1:0]  hi_idx;
        logic [DATA_W-1:0] hi_data;
    } t_wr_req;

endpackage

### hw/rtl/aame_regfile.sv
// General-purpose register file: NUM_REGS x 32 flip-flops, five read ports.
// Depends on aame_pkg for sizes and the write request struct.
module aame_regfile
    import aame_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_wr_req           i_wr,
    input  logic [IDX_W-1:0]  i_first_idx,
    input  logic [IDX_W-1:0]  i_left_idx,
    input  logic [IDX_W-1:0]  i_right_idx,
    input  logic [IDX_W-1:0]  i_dest_idx,
    input  logic [IDX_W-1:0]  i_high_dest_idx,
    output logic [DATA_W-1:0] o_first_val,
    output logic [DATA_W-1:0] o_left_val,
    output logic [DATA_W-1:0] o_right_val,
    output logic [DATA_W-1:0] o_dest_val,
    output logic [DATA_W-1:0] o_high_dest_val
);

    logic [DATA_W-1:0] r_regs [NUM_REGS];

    // Drop the low write when the high half targets the same register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (i_wr.lo_en && !(i_wr.hi_en && (i_wr.hi_idx == i_wr.lo_idx))) begin
                r_regs[i_wr.lo_idx] <= i_wr.lo_data;
            end
            if (i_wr.hi_en) begin
                r_regs[i_wr.hi_idx] <= i_wr.hi_data;
            end
        end
    end

    // Read ports
    assign o_first_val     = r_regs[i_first_idx];
    assign o_left_val      = r_regs[i_left_idx];
    assign o_right_val     = r_regs[i_right_idx];
    assign o_dest_val      = r_regs[i_dest_idx];
    assign o_high_dest_val = r_regs[i_high_dest_idx];

endmodule

### hw/rtl/aame_alu.sv
// Combinational datapath: 33-bit adder, logic ops, 33x33 multiplier with
// 64-bit accumulate, flag update and write request. Depends on aame_pkg.
module aame_alu
    import aame_pkg::*;
(
    input  logic [FUNC_W-1:0] i_func,
    input  logic              i_set_flags,
    input  logic              i_signed_multiply,
    input  logic [IDX_W-1:0]  i_dest_idx,
    input  logic [IDX_W-1:0]  i_high_dest_idx,
    input  logic [DATA_W-1:0] i_first_val,
    input  logic [DATA_W-1:0] i_operand_value,
    input  logic [DATA_W-1:0] i_left_val,
    input  logic [DATA_W-1:0] i_right_val,
    input  logic [DATA_W-1:0] i_dest_val,
    input  logic [DATA_W-1:0] i_high_dest_val,
    input  t_flags            i_flags,
    output logic [DATA_W-1:0] o_result_low,
    output logic [DATA_W-1:0] o_result_high,
    output t_flags            o_flags,
    output t_wr_req           o_wr
);

    t_func                   func;
    logic [DATA_W-1:0]       add_x;
    logic [DATA_W-1:0]       add_y;
    logic                    add_cin;
    logic [DATA_W:0]         add_sum;
    logic                    add_v;
    logic                    mul_sgn;
    logic [DATA_W:0]         mul_l;
    logic [DATA_W:0]         mul_r;
    logic signed [2*DATA_W+1:0] prod_full;
    logic [2*DATA_W-1:0]     prod;
    logic [2*DATA_W-1:0]     mac;

    assign func = t_func'(i_func);

    // Pick adder operands: subtraction adds the inverted subtrahend
    always_comb begin
        add_x   = i_first_val;
        add_y   = i_operand_value;
        add_cin = 1'b0;
        case (func)
            FN_SUB, FN_CMP: begin
                add_y   = ~i_operand_value;
                add_cin = 1'b1;
            end
            FN_RSB: begin
                add_x   = i_operand_value;
                add_y   = ~i_first_val;
                add_cin = 1'b1;
            end
            FN_ADC: add_cin = i_flags.c;
            FN_SBC: begin
                add_y   = ~i_operand_value;
                add_cin = i_flags.c;
            end
            FN_RSC: begin
                add_x   = i_operand_value;
                add_y   = ~i_first_val;
                add_cin = i_flags.c;
            end
            default: begin
                add_x   = i_first_val;
                add_y   = i_operand_value;
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DATA_W{1'b0}}, add_cin};
    assign add_v   = ((add_x[DATA_W-1] ^ add_sum[DATA_W-1])
                    & (add_y[DATA_W-1] ^ add_sum[DATA_W-1]));

    // Multiplier: sign-extend to 33 bits only for signed long forms
    assign mul_sgn   = i_signed_multiply & ((func == FN_MULL) | (func == FN_MLAL));
    assign mul_l     = {mul_sgn & i_left_val[DATA_W-1], i_left_val};
    assign mul_r     = {mul_sgn & i_right_val[DATA_W-1], i_right_val};
    assign prod_full = $signed(mul_l) * $signed(mul_r);
    assign prod      = prod_full[2*DATA_W-1:0];
    assign mac       = prod + ((func == FN_MLAL) ? {i_high_dest_val, i_dest_val}
                                                 : {(2*DATA_W){1'b0}});

    // Select result, flags and register writes
    always_comb begin
        o_result_low  = '0;
        o_result_high = '0;
        o_flags       = i_flags;
        o_wr.lo_en    = 1'b0;
        o_wr.lo_idx   = i_dest_idx;
        o_wr.hi_en    = 1'b0;
        o_wr.hi_idx   = i_high_dest_idx;
        case (func)
            FN_AND, FN_EOR, FN_ORR, FN_MOV, FN_BIC, FN_MVN, FN_TST, FN_TEQ: begin
                case (func)
                    FN_AND, FN_TST: o_result_low = i_first_val & i_operand_value;
                    FN_EOR, FN_TEQ: o_result_low = i_first_val ^ i_operand_value;
                    FN_ORR:         o_result_low = i_first_val | i_operand_value;
                    FN_MOV:         o_result_low = i_operand_value;
                    FN_BIC:         o_result_low = i_first_val & ~i_operand_value;
                    default:        o_result_low = ~i_operand_value;
                endcase
                if (i_set_flags || func == FN_TST || func == FN_TEQ) begin
                    o_flags.n = o_result_low[DATA_W-1];
                    o_flags.z = (o_result_low == '0);
                end
                o_wr.lo_en = (func != FN_TST) && (func != FN_TEQ);
            end
            FN_SUB, FN_RSB, FN_ADD, FN_ADC, FN_SBC, FN_RSC, FN_CMP, FN_CMN: begin
                o_result_low = add_sum[DATA_W-1:0];
                if (i_set_flags || func == FN_CMP || func == FN_CMN) begin
                    o_flags.n = add_sum[DATA_W-1];
                    o_flags.z = (add_sum[DATA_W-1:0] == '0);
                    o_flags.c = add_sum[DATA_W];
                    o_flags.v = add_v;
                end
                o_wr.lo_en = (func != FN_CMP) && (func != FN_CMN);
            end
            FN_MUL, FN_MLA: begin
                o_result_low = prod[DATA_W-1:0]
                             + ((func == FN_MLA) ? i_first_val : {DATA_W{1'b0}});
                if (i_set_flags) begin
                    o_flags.n = o_result_low[DATA_W-1];
                    o_flags.z = (o_result_low == '0);
                end
                o_wr.lo_en = 1'b1;
            end
            FN_MULL, FN_MLAL: begin
                o_result_low  = mac[DATA_W-1:0];
                o_result_high = mac[2*DATA_W-1:DATA_W];
                if (i_set_flags) begin
                    o_flags.n = mac[2*DATA_W-1];
                    o_flags.z = (mac == '0);
                end
                o_wr.lo_en = 1'b1;
                o_wr.hi_en = 1'b1;
            end
            default: begin
                o_result_low  = '0;
                o_result_high = '0;
            end
        endcase
        o_wr.lo_data = o_result_low;
        o_wr.hi_data = o_result_high;
    end

endmodule

### hw/rtl/arm_alu_multiply_execute.sv
// Top level of the ALU / multiply execute block: input register, handshake,
// flag state and result register. Depends on aame_pkg, aame_regfile, aame_alu.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one operation per beat:
//   opcode, flag-set bit, register indices, second operand and signedness.
//   Output channel (o_out_valid / i_out_stall) returns one beat per input
//   beat: low and high result words and the NZCV flags after the operation.
//   An accepted beat sits in the input register, where it reads the
//   register file and flags, runs through the adder or the 33x33
//   multiplier and 64-bit accumulator, and once it advances commits its
//   register writes and flags and lands in the result register. Throughput
//   is one beat per cycle while the receiver does not stall; each beat
//   commits before the next one reads, so dependent operations follow back
//   to back without bubbles.
//   The cycle time is set by the multiply-accumulate path.
//   While the receiver stalls a full result register, the input register
//   keeps its beat and o_in_stall rises once both are occupied.
//   Reset (synchronous, active low) clears all sixteen registers, the flags
//   and both valid bits.
module arm_alu_multiply_execute
    import aame_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic                i_set_flags,
    input  logic [IDX_W-1:0]    i_dest_index,
    input  logic [IDX_W-1:0]    i_first_index,
    input  logic [DATA_W-1:0]   i_operand_value,
    input  logic [IDX_W-1:0]    i_mul_left_index,
    input  logic [IDX_W-1:0]    i_mul_right_index,
    input  logic [IDX_W-1:0]    i_high_dest_index,
    input  logic                i_signed_multiply,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [DATA_W-1:0]   o_result_low,
    output logic [DATA_W-1:0]   o_result_high,
    output logic                o_flag_negative,
    output logic                o_flag_zero,
    output logic                o_flag_carry,
    output logic                o_flag_overflow
);

    // Input register
    logic                r_in_valid;
    logic [FUNC_W-1:0]   r_func;
    logic                r_set_flags;
    logic [IDX_W-1:0]    r_dest;
    logic [IDX_W-1:0]    r_first;
    logic [DATA_W-1:0]   r_operand;
    logic [IDX_W-1:0]    r_left;
    logic [IDX_W-1:0]    r_right;
    logic [IDX_W-1:0]    r_high_dest;
    logic                r_signed;

    // Architectural flags and result register
    t_flags              r_flags;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_result_low;
    logic [DATA_W-1:0]   r_result_high;
    t_flags              r_out_flags;

    logic                accept;
    logic                advance;
    logic                n_in_valid;
    logic                n_out_valid;

    logic [DATA_W-1:0]   first_val;
    logic [DATA_W-1:0]   left_val;
    logic [DATA_W-1:0]   right_val;
    logic [DATA_W-1:0]   dest_val;
    logic [DATA_W-1:0]   high_dest_val;
    logic [DATA_W-1:0]   alu_low;
    logic [DATA_W-1:0]   alu_high;
    t_flags              alu_flags;
    t_wr_req             alu_wr;
    t_wr_req             rf_wr;

    // Handshake: move a beat on when the result register is free or draining
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign accept      = i_in_valid && !o_in_stall;
    assign n_in_valid  = accept || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_flags <= alu_flags;
            end
        end
    end

    // Capture the incoming beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func      <= i_func;
            r_set_flags <= i_set_flags;
            r_dest      <= i_dest_index;
            r_first     <= i_first_index;
            r_operand   <= i_operand_value;
            r_left      <= i_mul_left_index;
            r_right     <= i_mul_right_index;
            r_high_dest <= i_high_dest_index;
            r_signed    <= i_signed_multiply;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result_low  <= alu_low;
            r_result_high <= alu_high;
            r_out_flags   <= alu_flags;
        end
    end

    // Commit register writes only when the beat advances
    always_comb begin
        rf_wr       = alu_wr;
        rf_wr.lo_en = alu_wr.lo_en && advance;
        rf_wr.hi_en = alu_wr.hi_en && advance;
    end

    aame_regfile u_regfile (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (rf_wr),
        .i_first_idx     (r_first),
        .i_left_idx      (r_left),
        .i_right_idx     (r_right),
        .i_dest_idx      (r_dest),
        .i_high_dest_idx (r_high_dest),
        .o_first_val     (first_val),
        .o_left_val      (left_val),
        .o_right_val     (right_val),
        .o_dest_val      (dest_val),
        .o_high_dest_val (high_dest_val)
    );

    aame_alu u_alu (
        .i_func            (r_func),
        .i_set_flags       (r_set_flags),
        .i_signed_multiply (r_signed),
        .i_dest_idx        (r_dest),
        .i_high_dest_idx   (r_high_dest),
        .i_first_val       (first_val),
        .i_operand_value   (r_operand),
        .i_left_val        (left_val),
        .i_right_val       (right_val),
        .i_dest_val        (dest_val),
        .i_high_dest_val   (high_dest_val),
        .i_flags           (r_flags),
        .o_result_low      (alu_low),
        .o_result_high     (alu_high),
        .o_flags           (alu_flags),
        .o_wr              (alu_wr)
    );

    assign o_out_valid     = r_out_valid;
    assign o_result_low    = r_result_low;
    assign o_result_high   = r_result_high;
    assign o_flag_negative = r_out_flags.n;
    assign o_flag_zero     = r_out_flags.z;
    assign o_flag_carry    = r_out_flags.c;
    assign o_flag_overflow = r_out_flags.v;

    // Stall only ever holds back a beat already in the input register
    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stall raised with empty input register");

    // An advancing beat always shows up as a result next cycle
    a_advance_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced beat missing from result register");

    // Reported flags match the architectural flags while a result is held
    a_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_flags == r_flags))
        else $error("reported flags differ from flag state");

    // No register write leaks out of a beat that does not advance
    a_write_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rf_wr.lo_en || rf_wr.hi_en) |-> advance)
        else $error("register write without advancing beat");

endmodule
